[rtl/cdq_pkg.sv]
// Shared constants, operation codes and index helpers for the circular deque.
package cdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int STEP_W = $clog2(IDX_W);

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_REAR   = 3'd3;
    localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
    localparam logic [2:0] OP_PEEK_REAR  = 3'd5;

    localparam logic [DATA_W-1:0] PEEK_FAIL = '1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MOD  = 4'b0010,
        S_EXEC = 4'b0100,
        S_READ = 4'b1000
    } state_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] s;
        s = {1'b0, i} + CNT_W'(1);
        return (s >= cap) ? '0 : s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] c;
        c = cap - CNT_W'(1);
        return (i == '0) ? c[IDX_W-1:0] : i - IDX_W'(1);
    endfunction

endpackage

[rtl/cdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/cdq_mod.sv]
// Bit-serial remainder unit: reduces two ring indices modulo the capacity.
module cdq_mod
    import cdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CNT_W-1:0] cap,
    input  logic [IDX_W-1:0] a,
    input  logic [IDX_W-1:0] b,
    output logic             done,
    output logic [IDX_W-1:0] ra,
    output logic [IDX_W-1:0] rb
);

    logic [IDX_W-1:0]  a_reg, b_reg;
    logic [IDX_W-1:0]  ra_reg, rb_reg;
    logic [IDX_W-1:0]  ra_next, rb_next;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  ta, tb, da, db;

    always_comb
    begin
        ta      = {ra_reg, a_reg[step_reg]};
        tb      = {rb_reg, b_reg[step_reg]};
        da      = ta - cap;
        db      = tb - cap;
        ra_next = (ta >= cap) ? da[IDX_W-1:0] : ta[IDX_W-1:0];
        rb_next = (tb >= cap) ? db[IDX_W-1:0] : tb[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(IDX_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - STEP_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg  <= a;
            b_reg  <= b;
            ra_reg <= '0;
            rb_reg <= '0;
        end
        else if (busy_reg)
        begin
            ra_reg <= ra_next;
            rb_reg <= rb_next;
        end
    end

    assign done = done_reg;
    assign ra   = ra_reg;
    assign rb   = rb_reg;

endmodule

[rtl/circular_deque.sv]
// Top level of the circular deque: request sequencer over the ring RAM.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tuser = mode, s_tdata = data_in
//  m_*       out  m_tvalid/m_tready  m_tdata = ok, data_out, is_empty, is_full, count
//  cfg_*     in   cfg_we             cfg_wdata = capacity
//
//  Push and pop pass through S_EXEC; peek goes on to S_READ for the registered ring RAM read.
//  While a capacity change leaves an index outside the ring, each request first passes
//  through the bit-serial remainder unit (S_MOD).
//  Reset empties the deque and sets capacity to 1024; ring contents are not cleared.
//  A stalled result holds in the output register while the next request is taken.
module circular_deque
    import cdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [31:0] data_in
    input  logic [2:0]       s_tuser,   // [2:0] mode
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // [0] ok, [32:1] data_out, [33] is_empty,
                                        // [34] is_full, [45:35] count
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cap_reg, cap_eff;
    logic [IDX_W-1:0]  front_reg, front_next;
    logic [IDX_W-1:0]  rear_reg, rear_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  fr_reg, fr_next;
    logic [IDX_W-1:0]  rr_reg, rr_next;
    logic [2:0]        mode_reg;
    logic [DATA_W-1:0] data_reg;
    logic              out_valid_reg, out_valid_next;
    logic              out_ok_reg, out_ok_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              out_empty_reg, out_empty_next;
    logic              out_full_reg, out_full_next;
    logic [CNT_W-1:0]  out_count_reg, out_count_next;

    logic              accept, out_free, empty, full, in_range;
    logic              mod_start, mod_done;
    logic [IDX_W-1:0]  mod_ra, mod_rb;
    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic [IDX_W-1:0]  f0, r0;

    cdq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(data_reg),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    cdq_mod u_mod (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mod_start),
        .cap  (cap_eff),
        .a    (front_reg),
        .b    (rear_reg),
        .done (mod_done),
        .ra   (mod_ra),
        .rb   (mod_rb)
    );

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg >= cap_eff);
    assign in_range  = ({1'b0, front_reg} < cap_eff) && ({1'b0, rear_reg} < cap_eff);
    assign mod_start = accept && !in_range;
    assign f0        = empty ? '0 : fr_reg;
    assign r0        = empty ? '0 : rr_reg;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        count_next     = count_reg;
        fr_next        = fr_reg;
        rr_next        = rr_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_ok_next    = out_ok_reg;
        out_data_next  = out_data_reg;
        out_empty_next = out_empty_reg;
        out_full_next  = out_full_reg;
        out_count_next = out_count_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fr_next    = front_reg;
                    rr_next    = rear_reg;
                    state_next = in_range ? S_EXEC : S_MOD;
                end
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    fr_next    = mod_ra;
                    rr_next    = mod_rb;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    out_ok_next   = 1'b0;
                    out_data_next = '0;
                    state_next    = S_IDLE;
                    unique case (mode_reg)
                        OP_PUSH_FRONT:
                        begin
                            if (!full)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = f0;
                                front_next  = idx_inc(f0, cap_eff);
                                if (empty)
                                begin
                                    rear_next = '0;
                                end
                                count_next  = count_reg + CNT_W'(1);
                                out_ok_next = 1'b1;
                            end
                        end
                        OP_PUSH_REAR:
                        begin
                            if (!full)
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = idx_dec(r0, cap_eff);
                                rear_next   = idx_dec(r0, cap_eff);
                                if (empty)
                                begin
                                    front_next = '0;
                                end
                                count_next  = count_reg + CNT_W'(1);
                                out_ok_next = 1'b1;
                            end
                        end
                        OP_POP_FRONT:
                        begin
                            if (!empty)
                            begin
                                front_next  = idx_dec(fr_reg, cap_eff);
                                count_next  = count_reg - CNT_W'(1);
                                out_ok_next = 1'b1;
                            end
                        end
                        OP_POP_REAR:
                        begin
                            if (!empty)
                            begin
                                rear_next   = idx_inc(rr_reg, cap_eff);
                                count_next  = count_reg - CNT_W'(1);
                                out_ok_next = 1'b1;
                            end
                        end
                        OP_PEEK_FRONT, OP_PEEK_REAR:
                        begin
                            if (empty)
                            begin
                                out_data_next = PEEK_FAIL;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = (mode_reg == OP_PEEK_FRONT)
                                             ? idx_dec(fr_reg, cap_eff) : rr_reg;
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    if (state_next == S_IDLE)
                    begin
                        out_valid_next = 1'b1;
                        out_empty_next = (count_next == '0);
                        out_full_next  = (count_next >= cap_eff);
                        out_count_next = count_next;
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b1;
                    out_data_next  = ram_rdata;
                    out_empty_next = empty;
                    out_full_next  = full;
                    out_count_next = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CNT_W'(DEPTH);
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= s_tuser;
            data_reg <= s_tdata;
        end
        fr_reg        <= fr_next;
        rr_reg        <= rr_next;
        out_ok_reg    <= out_ok_next;
        out_data_reg  <= out_data_next;
        out_empty_reg <= out_empty_next;
        out_full_reg  <= out_full_next;
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_count_reg, out_full_reg, out_empty_reg,
                       out_data_reg, out_ok_reg};

endmodule

[rtl/cdq_checker.sv]
// Port-level checker for the circular deque, bound to the top level.
module cdq_checker
    import cdq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    logic              ok;
    logic [DATA_W-1:0] dout;
    logic              is_empty;
    logic              is_full;
    logic [CNT_W-1:0]  count;

    assign ok       = m_tdata[0];
    assign dout     = m_tdata[32:1];
    assign is_empty = m_tdata[33];
    assign is_full  = m_tdata[34];
    assign count    = m_tdata[45:35];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (is_empty == (count == '0)))
        else $error("empty flag disagrees with count");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (count <= CNT_W'(DEPTH)) && !(is_full && is_empty))
        else $error("count out of range");

    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !ok |-> (dout == '0) || (dout == PEEK_FAIL))
        else $error("failed request carries data");

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
